// File: hw/rtl/assert_macros.svh
// assertion helpers used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define VN4_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// next-cycle implication, disabled in reset
`define VN4_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// File: hw/rtl/vn4_pkg.sv
// ----------------------------------------------------------------------------
// vn4_pkg
// Types and widths for the four-component vector normalize core.
// ----------------------------------------------------------------------------
package vn4_pkg;

   localparam int COMP_W    = 24;  // Q8.16 component
   localparam int ABS_W     = 24;  // magnitude of a component
   localparam int SQ_W      = 48;  // one square
   localparam int SUM_W     = 49;  // sum of four squares, Q17.32
   localparam int RAD_W     = 50;  // radicand padded to an even width
   localparam int ROOT_W    = 25;  // length, Q9.16
   localparam int REM_W     = 28;  // square root partial remainder
   localparam int QUO_W     = 23;  // quotient bits, Q1.22
   localparam int DREM_W    = 26;  // divide partial remainder
   localparam int UNIT_W    = 24;
   localparam int LANES     = 4;

   typedef struct packed {
      logic signed [COMP_W-1:0] comp_x;
      logic signed [COMP_W-1:0] comp_y;
      logic signed [COMP_W-1:0] comp_z;
      logic signed [COMP_W-1:0] comp_w;
   } req_type;

   typedef struct packed {
      logic signed [UNIT_W-1:0] unit_x;
      logic signed [UNIT_W-1:0] unit_y;
      logic signed [UNIT_W-1:0] unit_z;
      logic signed [UNIT_W-1:0] unit_w;
      logic        [ROOT_W-1:0] magnitude;
      logic                     zero_length;
   } rsp_type;

endpackage

// File: hw/rtl/vec4_normalize_core.sv
// ----------------------------------------------------------------------------
// vec4_normalize_core
// Normalizes a four-component Q8.16 vector to Q1.22 and reports its length.
// ----------------------------------------------------------------------------
// One item enters per cycle while the pipeline advances. Each accepted item
// passes through one stage of absolute value and squaring, one stage of
// summing, 25 digit stages of a pipelined square root, 23 stages of a
// pipelined restoring divider (four lanes in parallel) and an output
// register. The whole pipeline advances whenever the output register is
// empty or being taken, so req_ready falls only while a result is held.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vec4_normalize_core import vn4_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic adv;

   // pipeline advances when the output stage can take a new item
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage 1: absolute value and square per lane
   logic signed [COMP_W-1:0] comp    [LANES];
   logic        [ABS_W-1:0]  abs_in  [LANES];
   logic        [ABS_W-1:0]  s1_abs_ff [LANES];
   logic                     s1_neg_ff [LANES];
   logic        [SQ_W-1:0]   s1_sq_ff  [LANES];
   logic                     s1_v_ff;

   assign comp[0] = req_data.comp_x;
   assign comp[1] = req_data.comp_y;
   assign comp[2] = req_data.comp_z;
   assign comp[3] = req_data.comp_w;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         abs_in[l] = comp[l][COMP_W-1] ? ABS_W'(-comp[l]) : ABS_W'(comp[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else if (adv) begin
         s1_v_ff <= req_valid;
      end
      if (adv) begin
         for (int l = 0; l < LANES; l++) begin
            s1_abs_ff[l] <= abs_in[l];
            s1_neg_ff[l] <= comp[l][COMP_W-1];
            s1_sq_ff[l]  <= abs_in[l] * abs_in[l];
         end
      end
   end

   // stage 2: sum of squares, loads the square root pipe
   logic [RAD_W-1:0]  sq_rad_ff  [ROOT_W+1];
   logic [REM_W-1:0]  sq_rem_ff  [ROOT_W+1];
   logic [ROOT_W-1:0] sq_root_ff [ROOT_W+1];
   logic [ABS_W-1:0]  sq_abs_ff  [ROOT_W+1][LANES];
   logic              sq_neg_ff  [ROOT_W+1][LANES];
   logic              sq_v_ff    [ROOT_W+1];
   logic [RAD_W-1:0]  sum_in;

   assign sum_in = RAD_W'(s1_sq_ff[0]) + RAD_W'(s1_sq_ff[1])
                 + RAD_W'(s1_sq_ff[2]) + RAD_W'(s1_sq_ff[3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_v_ff[0] <= 1'b0;
      end else if (adv) begin
         sq_v_ff[0] <= s1_v_ff;
      end
      if (adv) begin
         sq_rad_ff[0]  <= {1'b0, sum_in[SUM_W-1:0]};
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         for (int l = 0; l < LANES; l++) begin
            sq_abs_ff[0][l] <= s1_abs_ff[l];
            sq_neg_ff[0][l] <= s1_neg_ff[l];
         end
      end
   end

   // square root: one result bit per stage
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      logic [REM_W-1:0] rem_t;
      logic [REM_W-1:0] trial;
      logic             fit;

      assign rem_t = {sq_rem_ff[k][REM_W-3:0], sq_rad_ff[k][RAD_W-1 -: 2]};
      assign trial = REM_W'({sq_root_ff[k], 2'b01});
      assign fit   = rem_t >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            sq_v_ff[k+1] <= sq_v_ff[k];
         end
         if (adv) begin
            sq_rad_ff[k+1]  <= {sq_rad_ff[k][RAD_W-3:0], 2'b00};
            sq_rem_ff[k+1]  <= fit ? rem_t - trial : rem_t;
            sq_root_ff[k+1] <= {sq_root_ff[k][ROOT_W-2:0], fit};
            sq_abs_ff[k+1]  <= sq_abs_ff[k];
            sq_neg_ff[k+1]  <= sq_neg_ff[k];
         end
      end
   end

   // divider: one quotient bit per stage, four lanes
   logic [DREM_W-1:0] dv_rem_ff [QUO_W][LANES];
   logic [QUO_W-1:0]  dv_quo_ff [QUO_W][LANES];
   logic [ROOT_W-1:0] dv_len_ff [QUO_W];
   logic              dv_neg_ff [QUO_W][LANES];
   logic              dv_v_ff   [QUO_W];

   for (genvar j = 0; j < QUO_W; j++) begin : g_div
      logic [DREM_W-1:0] src_rem [LANES];
      logic [QUO_W-1:0]  src_quo [LANES];
      logic              src_neg [LANES];
      logic [ROOT_W-1:0] src_len;
      logic              src_v;
      logic [DREM_W-1:0] rem_t [LANES];
      logic              fit   [LANES];

      if (j == 0) begin : g_first
         // numerator is abs << 22; its top bits start below the length
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               src_rem[l] = DREM_W'(sq_abs_ff[ROOT_W][l][ABS_W-1:1]);
               src_quo[l] = '0;
               src_neg[l] = sq_neg_ff[ROOT_W][l];
               rem_t[l]   = {src_rem[l][DREM_W-2:0], sq_abs_ff[ROOT_W][l][0]};
            end
         end
         assign src_len = sq_root_ff[ROOT_W];
         assign src_v   = sq_v_ff[ROOT_W];
      end else begin : g_next
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               src_rem[l] = dv_rem_ff[j-1][l];
               src_quo[l] = dv_quo_ff[j-1][l];
               src_neg[l] = dv_neg_ff[j-1][l];
               rem_t[l]   = {src_rem[l][DREM_W-2:0], 1'b0};
            end
         end
         assign src_len = dv_len_ff[j-1];
         assign src_v   = dv_v_ff[j-1];
      end

      always_comb begin
         for (int l = 0; l < LANES; l++) begin
            fit[l] = rem_t[l] >= DREM_W'(src_len);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_v_ff[j] <= src_v;
         end
         if (adv) begin
            dv_len_ff[j] <= src_len;
            for (int l = 0; l < LANES; l++) begin
               dv_rem_ff[j][l] <= fit[l] ? rem_t[l] - DREM_W'(src_len) : rem_t[l];
               dv_quo_ff[j][l] <= {src_quo[l][QUO_W-2:0], fit[l]};
               dv_neg_ff[j][l] <= src_neg[l];
            end
         end
      end
   end

   // output stage: sign, zero-length handling
   logic [UNIT_W-1:0] unit_in [LANES];
   logic              zero_in;
   rsp_type           rsp_ff;
   logic              rsp_v_ff;

   assign zero_in = dv_len_ff[QUO_W-1] == '0;

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         if (zero_in) begin
            unit_in[l] = '0;
         end else if (dv_neg_ff[QUO_W-1][l]) begin
            unit_in[l] = UNIT_W'(-UNIT_W'(dv_quo_ff[QUO_W-1][l]));
         end else begin
            unit_in[l] = UNIT_W'(dv_quo_ff[QUO_W-1][l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff <= 1'b0;
      end else if (adv) begin
         rsp_v_ff <= dv_v_ff[QUO_W-1];
      end
      if (adv) begin
         rsp_ff.unit_x      <= unit_in[0];
         rsp_ff.unit_y      <= unit_in[1];
         rsp_ff.unit_z      <= unit_in[2];
         rsp_ff.unit_w      <= unit_in[3];
         rsp_ff.magnitude   <= dv_len_ff[QUO_W-1];
         rsp_ff.zero_length <= zero_in;
      end
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_ff;

   // checks
   `VN4_ASSERT_IMPLY(a_zero_mag, clock, reset, rsp_valid && rsp_data.zero_length, rsp_data.magnitude == '0)
   `VN4_ASSERT_IMPLY(a_nonzero_mag, clock, reset, rsp_valid && !rsp_data.zero_length, rsp_data.magnitude != '0)
   `VN4_ASSERT_IMPLY(a_stall_only_held, clock, reset, !req_ready, rsp_valid && !rsp_ready)
   `VN4_ASSERT_NEXT(a_held_result, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

endmodule
